// ===== rtl/zlfa_pkg.sv =====
// Shared types, codes and constants of the Zech-log field ALU.
`timescale 1ns / 1ps
`default_nettype none
package zlfa_pkg;

  localparam int LOG_W          = 13;
  localparam int MAX_GROUP_DEF  = 4096;
  localparam int MAX_PRIME_DEF  = 4096;
  localparam logic [LOG_W-1:0] ZERO_LOG = '1;  // -1 encodes the zero element

  typedef enum logic [3:0] {
    MODE_NEG   = 4'd0,
    MODE_ADD   = 4'd1,
    MODE_SUB   = 4'd2,
    MODE_INV   = 4'd3,
    MODE_MUL   = 4'd4,
    MODE_DIV   = 4'd5,
    MODE_POW   = 4'd6,
    MODE_EMBED = 4'd7,
    MODE_ZLOAD = 4'd8,
    MODE_ELOAD = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    CFG_GROUP_ORDER = 2'd0,
    CFG_LOG_MINUS1  = 2'd1,
    CFG_CHAR_PRIME  = 2'd2
  } cfg_idx_t;

  // beat context carried alongside the first remainder pipeline
  typedef struct packed {
    logic        valid;
    mode_t       mode;
    logic        a_zero;
    logic        b_zero;
    logic        p_neg;
    logic        k_neg;
    logic [11:0] idx;
    logic [12:0] tv;
  } t1_t;

  // beat context carried alongside the final reduction
  typedef struct packed {
    logic        valid;
    logic        tbl;
    logic        rz;
    logic [12:0] dres;
  } t2_t;

endpackage
`default_nettype wire

// ===== rtl/zlfa_rem.sv =====
// Pipelined restoring remainder: padding stages pass through, then one dividend bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module zlfa_rem import zlfa_pkg::*; #(
  parameter int DW  = 12,
  parameter int LAT = 12
) (
  input  wire logic          clk,
  input  wire logic [DW-1:0] in_dividend,
  input  wire logic [12:0]   in_divisor,
  output logic      [12:0]   out_rem
);

  localparam int PAD = LAT - DW;

  logic [12:0]   rem_r [LAT];
  logic [DW-1:0] dvd_r [LAT];

  for (genvar s = 0; s < LAT; s++) begin : g_stage
    logic [12:0]   r_in;
    logic [DW-1:0] q_in;
    if (s == 0) begin : g_first
      assign r_in = '0;
      assign q_in = in_dividend;
    end else begin : g_next
      assign r_in = rem_r[s-1];
      assign q_in = dvd_r[s-1];
    end
    if (s < PAD) begin : g_pad
      always_ff @(posedge clk) begin
        rem_r[s] <= r_in;
        dvd_r[s] <= q_in;
      end
    end else begin : g_bit
      localparam int BIT = DW - 1 - (s - PAD);
      logic [13:0] t;
      assign t = {r_in, q_in[BIT]};
      always_ff @(posedge clk) begin
        if (t >= {1'b0, in_divisor}) begin
          rem_r[s] <= 13'(t - {1'b0, in_divisor});
        end else begin
          rem_r[s] <= t[12:0];
        end
        dvd_r[s] <= q_in;
      end
    end
  end

  assign out_rem = rem_r[LAT-1];

endmodule
`default_nettype wire

// ===== rtl/zech_log_field_alu.sv =====
// Top level: Zech-log GF(p^m) arithmetic unit with table memories.
// Path: S0, S1, first remainder pipeline, S2, S3, S4, final reduction, output register.
// Throughput: one item per cycle; busy stays low, tables are read once per item.
// The depth is set by the 44-bit remainder pipeline and the 14-bit final reduction.
// Reset sets config defaults, clears the valids; data regs and tables are not cleared.
// The receiver cannot stall: out_valid is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module zech_log_field_alu import zlfa_pkg::*; #(
  parameter int MAX_GROUP_ORDER = MAX_GROUP_DEF,
  parameter int MAX_PRIME       = MAX_PRIME_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         in_mode,
  input  wire logic signed [12:0] in_operand_a,
  input  wire logic signed [12:0] in_operand_b,
  input  wire logic signed [31:0] in_exponent,
  input  wire logic signed [31:0] in_integer_value,
  input  wire logic [11:0]        in_table_index,
  input  wire logic signed [12:0] in_table_value,
  output logic                    out_valid,
  output logic signed [12:0]      out_result,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data
);

  localparam int ZAW  = (MAX_GROUP_ORDER > 1) ? $clog2(MAX_GROUP_ORDER) : 1;
  localparam int EAW  = (MAX_PRIME > 1) ? $clog2(MAX_PRIME) : 1;
  localparam int LAT1 = 44;
  localparam int LAT2 = 14;

  function automatic logic [12:0] mod_fold(input logic [13:0] s, input logic [12:0] n);
    return (s >= {1'b0, n}) ? 13'(s - {1'b0, n}) : s[12:0];
  endfunction

  // configuration
  logic [12:0] go_r;
  logic [11:0] lom_r;
  logic [12:0] cp_r;
  logic [12:0] grp_n, chr_p;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      go_r  <= 13'd1;
      lom_r <= '0;
      cp_r  <= 13'd2;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_GROUP_ORDER: go_r  <= cfg_data;
        CFG_LOG_MINUS1:  lom_r <= cfg_data[11:0];
        CFG_CHAR_PRIME:  cp_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    grp_n = go_r;
    if (go_r == '0) grp_n = 13'd1;
    else if (32'(go_r) > 32'(MAX_GROUP_ORDER)) grp_n = 13'(MAX_GROUP_ORDER);
    chr_p = cp_r;
    if (cp_r < 13'd2) chr_p = 13'd2;
    else if (32'(cp_r) > 32'(MAX_PRIME)) chr_p = 13'(MAX_PRIME);
  end

  // S0: input capture
  logic        s0_valid_r;
  mode_t       s0_mode_r;
  logic [12:0] s0_a_r, s0_b_r, s0_tv_r;
  logic [31:0] s0_e_r, s0_k_r;
  logic [11:0] s0_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else        s0_valid_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s0_mode_r <= mode_t'(in_mode);
      s0_a_r    <= in_operand_a;
      s0_b_r    <= in_operand_b;
      s0_e_r    <= in_exponent;
      s0_k_r    <= in_integer_value;
      s0_idx_r  <= in_table_index;
      s0_tv_r   <= in_table_value;
    end
  end

  // S1: product magnitude and integer magnitude
  t1_t         s1_r;
  logic [43:0] s1_prod_r;
  logic [31:0] s1_kmag_r;
  logic [11:0] s1_a_r, s1_b_r;
  logic [31:0] e_mag;

  assign e_mag = s0_e_r[31] ? 32'(-s0_e_r) : s0_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_r.valid <= 1'b0;
    else        s1_r.valid <= s0_valid_r;
    s1_r.mode   <= s0_mode_r;
    s1_r.a_zero <= s0_a_r[12];
    s1_r.b_zero <= s0_b_r[12];
    s1_r.p_neg  <= s0_e_r[31];
    s1_r.k_neg  <= s0_k_r[31];
    s1_r.idx    <= s0_idx_r;
    s1_r.tv     <= s0_tv_r;
    s1_prod_r   <= 44'(s0_a_r[11:0]) * 44'(e_mag);
    s1_kmag_r   <= s0_k_r[31] ? 32'(-s0_k_r) : s0_k_r;
    s1_a_r      <= s0_a_r[11:0];
    s1_b_r      <= s0_b_r[11:0];
  end

  // first reduction
  logic [12:0] rp, ra, rb, rl, rk;
  t1_t         d1_r [LAT1];

  zlfa_rem #(.DW(44), .LAT(LAT1)) u_rem_pow (
    .clk(clk), .in_dividend(s1_prod_r), .in_divisor(grp_n), .out_rem(rp));
  zlfa_rem #(.DW(12), .LAT(LAT1)) u_rem_a (
    .clk(clk), .in_dividend(s1_a_r), .in_divisor(grp_n), .out_rem(ra));
  zlfa_rem #(.DW(12), .LAT(LAT1)) u_rem_b (
    .clk(clk), .in_dividend(s1_b_r), .in_divisor(grp_n), .out_rem(rb));
  zlfa_rem #(.DW(12), .LAT(LAT1)) u_rem_lom (
    .clk(clk), .in_dividend(lom_r), .in_divisor(grp_n), .out_rem(rl));
  zlfa_rem #(.DW(32), .LAT(LAT1)) u_rem_k (
    .clk(clk), .in_dividend(s1_kmag_r), .in_divisor(chr_p), .out_rem(rk));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT1; i++) d1_r[i] <= '0;
    end else begin
      d1_r[0] <= s1_r;
      for (int i = 1; i < LAT1; i++) d1_r[i] <= d1_r[i-1];
    end
  end

  // S2: direct results
  t1_t         q1;
  logic [12:0] nega, negb, inv_v, mul_v, div_v, pow_v, eidx, dres_nxt;
  logic        s2_valid_r, s2_az_r, s2_bz_r;
  mode_t       s2_mode_r;
  logic [12:0] s2_ca_r, s2_y_r, s2_dres_r, s2_eidx_r, s2_tv_r;
  logic [11:0] s2_idx_r;

  assign q1 = d1_r[LAT1-1];

  always_comb begin
    nega  = mod_fold(14'(ra) + 14'(rl), grp_n);
    negb  = mod_fold(14'(rb) + 14'(rl), grp_n);
    inv_v = (ra == '0) ? '0 : 13'(grp_n - ra);
    mul_v = mod_fold(14'(ra) + 14'(rb), grp_n);
    div_v = (ra >= rb) ? 13'(ra - rb) : 13'(ra - rb + grp_n);
    pow_v = (q1.p_neg && rp != '0) ? 13'(grp_n - rp) : rp;
    eidx  = (q1.k_neg && rk != '0) ? 13'(chr_p - rk) : rk;
    case (q1.mode)
      MODE_NEG: dres_nxt = q1.a_zero ? ZERO_LOG : nega;
      MODE_INV: dres_nxt = q1.a_zero ? ZERO_LOG : inv_v;
      MODE_MUL: dres_nxt = (q1.a_zero || q1.b_zero) ? ZERO_LOG : mul_v;
      MODE_DIV: dres_nxt = (q1.a_zero || q1.b_zero) ? ZERO_LOG : div_v;
      MODE_POW: dres_nxt = q1.a_zero ? ZERO_LOG : pow_v;
      MODE_ZLOAD, MODE_ELOAD: dres_nxt = q1.tv;
      default: dres_nxt = ZERO_LOG;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s2_valid_r <= 1'b0;
    else        s2_valid_r <= q1.valid;
  end

  always_ff @(posedge clk) begin
    s2_mode_r <= q1.mode;
    s2_az_r   <= q1.a_zero;
    s2_bz_r   <= q1.b_zero;
    s2_ca_r   <= ra;
    s2_y_r    <= (q1.mode == MODE_SUB) ? negb : rb;
    s2_dres_r <= dres_nxt;
    s2_eidx_r <= eidx;
    s2_idx_r  <= q1.idx;
    s2_tv_r   <= q1.tv;
  end

  // S3: table access
  logic [12:0] zech_mem [MAX_GROUP_ORDER];
  logic [12:0] emb_mem  [MAX_PRIME];
  logic [12:0] diff, lo;
  logic [31:0] zrd_w, erd_w, wr_w;
  logic        zwr, ewr;
  logic [12:0] zd_r, ed_r;
  logic        s3_valid_r, s3_tbl_r;
  mode_t       s3_mode_r;
  logic [12:0] s3_dres_r, s3_lo_r;
  logic        tbl_nxt;
  logic [12:0] dres3;

  assign diff  = (s2_ca_r >= s2_y_r) ? 13'(s2_ca_r - s2_y_r) : 13'(s2_y_r - s2_ca_r);
  assign lo    = (s2_ca_r >= s2_y_r) ? s2_y_r : s2_ca_r;
  assign zrd_w = 32'(diff);
  assign erd_w = 32'(s2_eidx_r);
  assign wr_w  = 32'(s2_idx_r);
  assign zwr   = s2_valid_r && s2_mode_r == MODE_ZLOAD && wr_w < 32'(MAX_GROUP_ORDER);
  assign ewr   = s2_valid_r && s2_mode_r == MODE_ELOAD && wr_w < 32'(MAX_PRIME);

  always_ff @(posedge clk) begin
    if (zwr) zech_mem[wr_w[ZAW-1:0]] <= s2_tv_r;
    zd_r <= zech_mem[zrd_w[ZAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ewr) emb_mem[wr_w[EAW-1:0]] <= s2_tv_r;
    ed_r <= emb_mem[erd_w[EAW-1:0]];
  end

  always_comb begin
    tbl_nxt = 1'b0;
    dres3   = s2_dres_r;
    case (s2_mode_r)
      MODE_ADD, MODE_SUB: begin
        if (s2_az_r)      dres3 = s2_bz_r ? ZERO_LOG : s2_y_r;
        else if (s2_bz_r) dres3 = s2_ca_r;
        else              tbl_nxt = 1'b1;
      end
      MODE_EMBED: tbl_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) s3_valid_r <= 1'b0;
    else        s3_valid_r <= s2_valid_r;
  end

  always_ff @(posedge clk) begin
    s3_mode_r <= s2_mode_r;
    s3_tbl_r  <= tbl_nxt;
    s3_dres_r <= dres3;
    s3_lo_r   <= lo;
  end

  // S4: final dividend
  t2_t         s4_r;
  logic [13:0] s4_dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s4_r.valid <= 1'b0;
    else        s4_r.valid <= s3_valid_r;
    s4_r.tbl  <= s3_tbl_r;
    s4_r.dres <= s3_dres_r;
    if (s3_mode_r == MODE_EMBED) begin
      s4_r.rz  <= ed_r[12];
      s4_dvd_r <= 14'(ed_r);
    end else begin
      s4_r.rz  <= zd_r[12];
      s4_dvd_r <= 14'(s3_lo_r) + 14'(zd_r);
    end
  end

  // final reduction
  logic [12:0] rf;
  t2_t         d2_r [LAT2];

  zlfa_rem #(.DW(14), .LAT(LAT2)) u_rem_fin (
    .clk(clk), .in_dividend(s4_dvd_r), .in_divisor(grp_n), .out_rem(rf));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT2; i++) d2_r[i] <= '0;
    end else begin
      d2_r[0] <= s4_r;
      for (int i = 1; i < LAT2; i++) d2_r[i] <= d2_r[i-1];
    end
  end

  // output register
  logic        out_valid_r;
  logic [12:0] out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= d2_r[LAT2-1].valid;
  end

  always_ff @(posedge clk) begin
    if (d2_r[LAT2-1].tbl) out_result_r <= d2_r[LAT2-1].rz ? ZERO_LOG : rf;
    else                  out_result_r <= d2_r[LAT2-1].dres;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  // checks
  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 64))
    else $error("result strobe without an accepted item");

  a_canon_range: assert property (@(posedge clk) disable iff (!rst_n)
    (q1.valid && !q1.a_zero) |-> (ra < grp_n))
    else $error("reduced operand not below group order");

  a_table_modes: assert property (@(posedge clk) disable iff (!rst_n)
    (s3_valid_r && s3_tbl_r) |->
      (s3_mode_r == MODE_ADD || s3_mode_r == MODE_SUB || s3_mode_r == MODE_EMBED))
    else $error("table path taken by a non-table mode");

endmodule
`default_nettype wire
